### sv/afr_pkg.sv
// Shared types and constants of the API frame receiver.
// No dependencies; imported by all modules of the block.
package afr_pkg;

  localparam int unsigned MaxPayloadDef = 128;

  localparam logic [7:0] DelimiterRst   = 8'h7E;
  localparam logic [7:0] Rx16TypeRst    = 8'h81;
  localparam logic [7:0] TxStatusRst    = 8'h89;
  localparam logic [7:0] CmdRespRst     = 8'h88;
  localparam logic [7:0] ChecksumBase   = 8'hFF;
  localparam logic [15:0] FixedFieldLen = 16'd5;

  localparam int unsigned CfgAddrW = 4;

  typedef enum logic [1:0] {
    REG_DELIMITER = 2'd0,
    REG_RX16_TYPE = 2'd1,
    REG_TX_STATUS = 2'd2,
    REG_CMD_RESP  = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PS_HUNT,
    PS_LEN_HI,
    PS_LEN_LO,
    PS_TYPE,
    PS_ADDR_HI,
    PS_ADDR_LO,
    PS_RSSI,
    PS_OPT,
    PS_PAYLOAD,
    PS_CKS,
    PS_TS_ID,
    PS_TS_STAT,
    PS_CR_ID,
    PS_CR_CMD1,
    PS_CR_CMD2,
    PS_CR_STAT
  } parse_state_e;

  typedef enum logic [2:0] {
    FS_PENDING  = 3'd0,
    FS_OK       = 3'd1,
    FS_CKS_ERR  = 3'd2,
    FS_UNKNOWN  = 3'd3,
    FS_OVERSIZE = 3'd4
  } frame_status_e;

  typedef enum logic [1:0] {
    FK_NONE      = 2'd0,
    FK_RX16      = 2'd1,
    FK_TX_STATUS = 2'd2,
    FK_CMD_RESP  = 2'd3
  } frame_kind_e;

  typedef struct packed {
    logic [7:0] delimiter;
    logic [7:0] rx16_type;
    logic [7:0] tx_status_type;
    logic [7:0] cmd_resp_type;
  } cfg_t;

  typedef struct packed {
    frame_status_e status;
    frame_kind_e   kind;
    logic [15:0]   src_addr;
    logic [7:0]    rssi;
    logic [7:0]    options;
    logic [7:0]    frame_id;
    logic [7:0]    rpt_status;
    logic          pay_valid;
    logic [7:0]    pay_byte;
    logic [6:0]    pay_index;
    logic [7:0]    pay_length;
  } result_t;

  // payload byte count announced by the length, for kinds that carry data
  function automatic logic [15:0] data_count(frame_kind_e kind, logic [15:0] len);
    logic [15:0] cnt;
    cnt = 16'd0;
    if ((kind == FK_RX16 || kind == FK_CMD_RESP) && len >= FixedFieldLen) begin
      cnt = len - FixedFieldLen;
    end
    return cnt;
  endfunction

endpackage

### sv/api_frame_receiver_top.sv
// Top level of the API frame receiver: config registers, parser, result buffer.
// Depends on afr_pkg, afr_cfg_regs, afr_parser and afr_out_skid.

// One received byte (or a timeout abort) goes in per request and exactly one
// result comes out per request, into the result register or its skid entry.
// A new byte can be accepted every cycle while in_stall_o is low; in_stall_o
// rises only once the output side has held off for two results, with the result
// register and its skid entry both full. Status and held frame fields reflect
// the frame in progress; payload bytes carry their index. The user writes type
// and delimiter codes over APB only while idle; the block does not enforce it.
module api_frame_receiver_top import afr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                abort_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          frame_status_o,
  output logic [1:0]          frame_kind_o,
  output logic [15:0]         source_address_o,
  output logic [7:0]          signal_strength_o,
  output logic [7:0]          packet_options_o,
  output logic [7:0]          frame_ident_o,
  output logic [7:0]          report_status_o,
  output logic                payload_valid_o,
  output logic [7:0]          payload_byte_o,
  output logic [6:0]          payload_index_o,
  output logic [7:0]          payload_length_o
);

  cfg_t    cfg;
  result_t res, res_out;
  logic    accept;
  logic    buf_full;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  afr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  afr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .abort_i   (abort_i),
    .cfg_i     (cfg),
    .result_o  (res)
  );

  afr_out_skid u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_out)
  );

  assign frame_status_o    = res_out.status;
  assign frame_kind_o      = res_out.kind;
  assign source_address_o  = res_out.src_addr;
  assign signal_strength_o = res_out.rssi;
  assign packet_options_o  = res_out.options;
  assign frame_ident_o     = res_out.frame_id;
  assign report_status_o   = res_out.rpt_status;
  assign payload_valid_o   = res_out.pay_valid;
  assign payload_byte_o    = res_out.pay_byte;
  assign payload_index_o   = res_out.pay_index;
  assign payload_length_o  = res_out.pay_length;

endmodule

### sv/afr_cfg_regs.sv
// APB-style configuration registers of the API frame receiver.
// Depends on afr_pkg.
module afr_cfg_regs import afr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  cfg_reg_e   sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = cfg_reg_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        REG_DELIMITER: cfg_d.delimiter      = pwdata[7:0];
        REG_RX16_TYPE: cfg_d.rx16_type      = pwdata[7:0];
        REG_TX_STATUS: cfg_d.tx_status_type = pwdata[7:0];
        REG_CMD_RESP:  cfg_d.cmd_resp_type  = pwdata[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_DELIMITER: prdata = {24'd0, cfg_q.delimiter};
      REG_RX16_TYPE: prdata = {24'd0, cfg_q.rx16_type};
      REG_TX_STATUS: prdata = {24'd0, cfg_q.tx_status_type};
      REG_CMD_RESP:  prdata = {24'd0, cfg_q.cmd_resp_type};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{delimiter: DelimiterRst, rx16_type: Rx16TypeRst,
                 tx_status_type: TxStatusRst, cmd_resp_type: CmdRespRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/afr_parser.sv
// Frame parse state machine: one serial byte per accepted request.
// Depends on afr_pkg; result is combinational from the next-state values.
module afr_parser import afr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic       abort_i,
  input  cfg_t       cfg_i,
  output result_t    result_o
);

  localparam int unsigned IdxW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MaxCount = 16'(MAX_PAYLOAD);

  parse_state_e    state_q, state_d;
  logic [15:0]     len_q, len_d;
  logic [7:0]      sum_q, sum_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     addr_q, addr_d;
  logic [7:0]      rssi_q, rssi_d;
  logic [7:0]      opt_q, opt_d;
  logic [7:0]      fid_q, fid_d;
  logic [7:0]      stat_q, stat_d;
  frame_kind_e     kind_q, kind_d;

  frame_status_e   status;
  logic            pv;
  logic [IdxW-1:0] pidx;
  logic [15:0]     cnt_q;
  logic [15:0]     cnt_d;
  logic [15:0]     idx_inc;
  logic [7:0]      sum_add;
  logic [IdxW+6:0] pidx_ext;

  assign sum_add = sum_q + rx_byte_i;
  assign idx_inc = 16'(idx_q) + 16'd1;
  assign cnt_q   = data_count(kind_q, len_q);
  assign cnt_d   = data_count(kind_d, len_d);

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    sum_d   = sum_q;
    idx_d   = idx_q;
    addr_d  = addr_q;
    rssi_d  = rssi_q;
    opt_d   = opt_q;
    fid_d   = fid_q;
    stat_d  = stat_q;
    kind_d  = kind_q;
    status  = FS_PENDING;
    pv      = 1'b0;
    pidx    = '0;

    if (abort_i) begin
      state_d = PS_HUNT;
    end else begin
      unique case (state_q)
        PS_HUNT: begin
          if (rx_byte_i == cfg_i.delimiter) begin
            len_d   = '0;
            sum_d   = '0;
            idx_d   = '0;
            addr_d  = '0;
            rssi_d  = '0;
            opt_d   = '0;
            fid_d   = '0;
            stat_d  = '0;
            kind_d  = FK_NONE;
            state_d = PS_LEN_HI;
          end
        end
        PS_LEN_HI: begin
          len_d   = {rx_byte_i, 8'd0};
          state_d = PS_LEN_LO;
        end
        PS_LEN_LO: begin
          len_d   = {len_q[15:8], rx_byte_i};
          state_d = PS_TYPE;
        end
        PS_TYPE: begin
          sum_d = sum_add;
          // priority among coinciding type codes: rx16, tx status, cmd response
          if (rx_byte_i == cfg_i.rx16_type) begin
            kind_d  = FK_RX16;
            state_d = PS_ADDR_HI;
          end else if (rx_byte_i == cfg_i.tx_status_type) begin
            kind_d  = FK_TX_STATUS;
            state_d = PS_TS_ID;
          end else if (rx_byte_i == cfg_i.cmd_resp_type) begin
            kind_d  = FK_CMD_RESP;
            state_d = PS_CR_ID;
          end else begin
            kind_d  = FK_NONE;
            status  = FS_UNKNOWN;
            state_d = PS_HUNT;
          end
          if (status == FS_PENDING && data_count(kind_d, len_q) > MaxCount) begin
            status  = FS_OVERSIZE;
            state_d = PS_HUNT;
          end
        end
        PS_ADDR_HI: begin
          addr_d  = {rx_byte_i, 8'd0};
          sum_d   = sum_add;
          state_d = PS_ADDR_LO;
        end
        PS_ADDR_LO: begin
          addr_d  = {addr_q[15:8], rx_byte_i};
          sum_d   = sum_add;
          state_d = PS_RSSI;
        end
        PS_RSSI: begin
          rssi_d  = rx_byte_i;
          sum_d   = sum_add;
          state_d = PS_OPT;
        end
        PS_OPT: begin
          opt_d   = rx_byte_i;
          sum_d   = sum_add;
          idx_d   = '0;
          state_d = (cnt_q != 16'd0) ? PS_PAYLOAD : PS_CKS;
        end
        PS_PAYLOAD: begin
          pv    = 1'b1;
          pidx  = idx_q;
          sum_d = sum_add;
          idx_d = idx_inc[IdxW-1:0];
          if (idx_inc >= cnt_q) begin
            state_d = PS_CKS;
          end
        end
        PS_TS_ID: begin
          fid_d   = rx_byte_i;
          sum_d   = sum_add;
          state_d = PS_TS_STAT;
        end
        PS_CR_ID: begin
          fid_d   = rx_byte_i;
          sum_d   = sum_add;
          state_d = PS_CR_CMD1;
        end
        PS_TS_STAT: begin
          stat_d  = rx_byte_i;
          sum_d   = sum_add;
          state_d = PS_CKS;
        end
        PS_CR_CMD1: begin
          sum_d   = sum_add;
          state_d = PS_CR_CMD2;
        end
        PS_CR_CMD2: begin
          sum_d   = sum_add;
          state_d = PS_CR_STAT;
        end
        PS_CR_STAT: begin
          stat_d  = rx_byte_i;
          sum_d   = sum_add;
          idx_d   = '0;
          state_d = (cnt_q != 16'd0) ? PS_PAYLOAD : PS_CKS;
        end
        PS_CKS: begin
          status  = ((ChecksumBase - sum_q) == rx_byte_i) ? FS_OK : FS_CKS_ERR;
          state_d = PS_HUNT;
        end
        default: state_d = PS_HUNT;
      endcase
    end
  end

  // zero-extend or truncate the index to the 7-bit output
  assign pidx_ext = {7'd0, pidx};

  always_comb begin
    result_o.status     = status;
    result_o.kind       = kind_d;
    result_o.src_addr   = addr_d;
    result_o.rssi       = rssi_d;
    result_o.options    = opt_d;
    result_o.frame_id   = fid_d;
    result_o.rpt_status = stat_d;
    result_o.pay_valid  = pv;
    result_o.pay_byte   = pv ? rx_byte_i : 8'd0;
    result_o.pay_index  = pidx_ext[6:0];
    result_o.pay_length = cnt_d[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PS_HUNT;
      len_q   <= '0;
      sum_q   <= '0;
      idx_q   <= '0;
      addr_q  <= '0;
      rssi_q  <= '0;
      opt_q   <= '0;
      fid_q   <= '0;
      stat_q  <= '0;
      kind_q  <= FK_NONE;
    end else if (accept_i) begin
      state_q <= state_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      idx_q   <= idx_d;
      addr_q  <= addr_d;
      rssi_q  <= rssi_d;
      opt_q   <= opt_d;
      fid_q   <= fid_d;
      stat_q  <= stat_d;
      kind_q  <= kind_d;
    end
  end

endmodule

### sv/afr_out_skid.sv
// Result register with a skid entry, so one more request is taken while the
// output side stalls. Depends on afr_pkg.
module afr_out_skid import afr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t data_o
);

  result_t out_q, out_d, skid_q, skid_d;
  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic    out_free;

  assign out_free = !out_valid_q || !stall_i;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = data_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule
